/* rtl/pcc_pkg.sv */
// pcc_pkg: shared types, codes and helpers for the polygon convexity classifier
// no dependencies; used by every pcc_* module and the top level
`default_nettype none

package pcc_pkg;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} pt_t;

	typedef struct packed {
		pt_t  pt;
		logic last;
	} vtx_t;

	// one edge check handed from the edge sequencer to the sign pipeline
	typedef struct packed {
		logic chk;
		logic done;
		logic many;
		pt_t  prev;
		pt_t  delta;
	} tok_t;

	localparam logic [1:0] AXIS_NEG_Z_Y = 2'd0;
	localparam logic [1:0] AXIS_Z_X     = 2'd1;
	localparam logic [1:0] AXIS_X_Y     = 2'd2;

	// two's complement -1 / 0 / +1, used for direction and angle sign
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	localparam logic [1:0] CNT_MAX = 2'd3;
	localparam logic [1:0] CNT_TWO = 2'd2;

	typedef enum logic [1:0] {
		CLS_LINE = 2'd0,
		CLS_CW   = 2'd1,
		CLS_CCW  = 2'd2,
		CLS_CPLX = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_CLOSE1,
		SEQ_CLOSE2
	} seq_t;

	function automatic logic [1:0] edge_dir(input pt_t d);
		logic [1:0] r;
		if (d.x != '0) begin
			r = d.x[31] ? DIR_POS : DIR_NEG;
		end else if (d.y != '0) begin
			r = d.y[31] ? DIR_POS : DIR_NEG;
		end else begin
			r = DIR_NONE;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/pcc_front.sv */
// pcc_front: configuration register, vertex intake and 2-D projection
// depends on pcc_pkg
`default_nettype none

module pcc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_data,
	input  wire logic               vtx_valid,
	output logic                    vtx_stall,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic               is_last,
	input  wire logic               q_full,
	output logic                    push,
	output pcc_pkg::vtx_t           push_item
);

	logic [1:0] axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= pcc_pkg::AXIS_X_Y;
		end else if (cfg_valid && cfg_ready) begin
			axis_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign vtx_stall = q_full;
	assign push      = vtx_valid && !q_full;

	always_comb begin
		push_item.last = is_last;
		case (axis_q)
			pcc_pkg::AXIS_NEG_Z_Y: begin
				push_item.pt.x = 32'd0 - $unsigned(pos_z);
				push_item.pt.y = $unsigned(pos_y);
			end
			pcc_pkg::AXIS_Z_X: begin
				push_item.pt.x = $unsigned(pos_z);
				push_item.pt.y = $unsigned(pos_x);
			end
			default: begin
				push_item.pt.x = $unsigned(pos_x);
				push_item.pt.y = $unsigned(pos_y);
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/pcc_queue.sv */
// pcc_queue: small first-in first-out queue of projected vertices
// depends on pcc_pkg
`default_nettype none

module pcc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pcc_pkg::vtx_t push_item,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output pcc_pkg::vtx_t      head
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pcc_pkg::vtx_t  slot_q [DEPTH];
	logic [IW-1:0]  wr_ptr_q;
	logic [IW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = count_q == FULL_CNT;
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/pcc_edge.sv */
// pcc_edge: edge sequencer; edge deltas, direction reversals, loop closing
// depends on pcc_pkg; feeds pcc_sign with one edge check per cycle while advance is high
`default_nettype none

module pcc_edge (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire pcc_pkg::vtx_t head,
	input  wire logic          advance,
	output logic               pop,
	output logic               tok_valid,
	output pcc_pkg::tok_t      tok
);

	pcc_pkg::seq_t state_q, state_nx;
	pcc_pkg::pt_t  first_q, second_q, last_q, prev_q;
	logic [1:0]    dir_q, dc_q, vc_q;

	pcc_pkg::pt_t  opa, d;
	logic          nz, rev, chk, done, step, close_go, short_done;
	logic [1:0]    nd, dc_chk;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pcc_pkg::SEQ_RUN: begin
				if (pop && close_go) begin
					state_nx = pcc_pkg::SEQ_CLOSE1;
				end
			end
			pcc_pkg::SEQ_CLOSE1: begin
				if (advance) begin
					state_nx = pcc_pkg::SEQ_CLOSE2;
				end
			end
			pcc_pkg::SEQ_CLOSE2: begin
				if (advance) begin
					state_nx = pcc_pkg::SEQ_RUN;
				end
			end
			default: state_nx = pcc_pkg::SEQ_RUN;
		endcase
	end

	// outputs and edge datapath
	always_comb begin
		case (state_q)
			pcc_pkg::SEQ_CLOSE1: opa = first_q;
			pcc_pkg::SEQ_CLOSE2: opa = second_q;
			default:             opa = head.pt;
		endcase
		d.x    = opa.x - last_q.x;
		d.y    = opa.y - last_q.y;
		nz     = (d.x != '0) || (d.y != '0);
		nd     = pcc_pkg::edge_dir(d);
		rev    = nd == (2'd0 - dir_q);
		dc_chk = dc_q + {1'b0, rev && (dc_q != pcc_pkg::CNT_MAX)};

		pop        = 1'b0;
		step       = 1'b0;
		chk        = 1'b0;
		short_done = 1'b0;
		close_go   = 1'b0;
		case (state_q)
			pcc_pkg::SEQ_RUN: begin
				pop        = advance && head_valid;
				step       = pop;
				chk        = (vc_q >= pcc_pkg::CNT_TWO) && nz;
				short_done = head.last && (vc_q < pcc_pkg::CNT_TWO);
				close_go   = head.last && (vc_q >= pcc_pkg::CNT_TWO);
			end
			pcc_pkg::SEQ_CLOSE1: begin
				step = advance;
				chk  = nz;
			end
			pcc_pkg::SEQ_CLOSE2: begin
				step = advance;
				chk  = 1'b1;
			end
			default: begin
				step = 1'b0;
			end
		endcase
		done = short_done || (state_q == pcc_pkg::SEQ_CLOSE2);

		tok_valid = step && (chk || done);
		tok.chk   = chk;
		tok.done  = done;
		tok.many  = (chk ? dc_chk : dc_q) == pcc_pkg::CNT_MAX;
		tok.prev  = prev_q;
		tok.delta = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcc_pkg::SEQ_RUN;
			dir_q   <= pcc_pkg::DIR_NONE;
			dc_q    <= '0;
			vc_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (step) begin
				if (done) begin
					dir_q <= pcc_pkg::DIR_NONE;
					dc_q  <= '0;
					vc_q  <= '0;
				end else if (state_q == pcc_pkg::SEQ_RUN) begin
					case (vc_q)
						2'd0: vc_q <= 2'd1;
						2'd1: begin
							vc_q  <= pcc_pkg::CNT_TWO;
							dir_q <= nd;
						end
						default: begin
							vc_q <= pcc_pkg::CNT_MAX;
							if (nz) begin
								dir_q <= nd;
								dc_q  <= dc_chk;
							end
						end
					endcase
				end else if (chk) begin
					dir_q <= nd;
					dc_q  <= dc_chk;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !done) begin
			if (state_q == pcc_pkg::SEQ_RUN) begin
				case (vc_q)
					2'd0: begin
						first_q <= head.pt;
						last_q  <= head.pt;
					end
					2'd1: begin
						second_q <= head.pt;
						last_q   <= head.pt;
						prev_q   <= d;
					end
					default: begin
						if (nz) begin
							prev_q <= d;
							last_q <= head.pt;
						end
					end
				endcase
			end else if (chk) begin
				prev_q <= d;
				last_q <= first_q;
			end
		end
	end

	a_close_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != pcc_pkg::SEQ_RUN |-> vc_q == pcc_pkg::CNT_MAX)
		else $error("closing steps without a full polygon");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok.done |=> vc_q == '0 && dc_q == '0)
		else $error("polygon state not cleared after final check");

	a_close_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcc_pkg::SEQ_CLOSE1 && advance |=> state_q == pcc_pkg::SEQ_CLOSE2)
		else $error("closing steps out of order");

endmodule

`default_nettype wire

/* rtl/pcc_sign.sv */
// pcc_sign: cross product pipeline, angle sign tracking and result register
// depends on pcc_pkg; takes edge checks from pcc_edge
`default_nettype none

module pcc_sign (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_valid,
	input  wire pcc_pkg::tok_t tok,
	output logic               advance,
	output logic               res_valid,
	input  wire logic          res_stall,
	output logic [1:0]         poly_class
);

	logic          valid_s1, valid_s2;
	pcc_pkg::tok_t tok_s1;
	logic          chk_s2, done_s2, many_s2;
	logic [31:0]   m1_s2, m2_s2;

	logic [1:0]    angle_q, angle_n;
	logic          cplx_q, cplx_n;
	logic          res_valid_q;
	pcc_pkg::cls_t cls_q, cls;

	logic signed [63:0] prod1, prod2;
	logic [31:0]        cr;
	logic               hold, load;

	assign prod1 = $signed(tok_s1.prev.x) * $signed(tok_s1.delta.y);
	assign prod2 = $signed(tok_s1.prev.y) * $signed(tok_s1.delta.x);

	assign hold    = valid_s2 && done_s2 && res_valid_q && res_stall;
	assign advance = !hold;
	assign load    = valid_s2 && done_s2 && advance;

	always_comb begin
		cr      = m1_s2 - m2_s2;
		angle_n = angle_q;
		cplx_n  = cplx_q;
		if (chk_s2) begin
			if (cr[31]) begin
				cplx_n  = cplx_q || (angle_q == pcc_pkg::DIR_POS);
				angle_n = pcc_pkg::DIR_NEG;
			end else if (cr != '0) begin
				cplx_n  = cplx_q || (angle_q == pcc_pkg::DIR_NEG);
				angle_n = pcc_pkg::DIR_POS;
			end
		end
		if (cplx_n || many_s2) begin
			cls = pcc_pkg::CLS_CPLX;
		end else if (angle_n == pcc_pkg::DIR_POS) begin
			cls = pcc_pkg::CLS_CCW;
		end else if (angle_n == pcc_pkg::DIR_NEG) begin
			cls = pcc_pkg::CLS_CW;
		end else begin
			cls = pcc_pkg::CLS_LINE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			angle_q     <= pcc_pkg::DIR_NONE;
			cplx_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= tok_valid;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					if (done_s2) begin
						angle_q <= pcc_pkg::DIR_NONE;
						cplx_q  <= 1'b0;
					end else begin
						angle_q <= angle_n;
						cplx_q  <= cplx_n;
					end
				end
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_s1  <= tok;
			chk_s2  <= tok_s1.chk;
			done_s2 <= tok_s1.done;
			many_s2 <= tok_s1.many;
			m1_s2   <= prod1[47:16];
			m2_s2   <= prod2[47:16];
		end
		if (load) begin
			cls_q <= cls;
		end
	end

	assign res_valid  = res_valid_q;
	assign poly_class = cls_q;

	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> valid_s2 && done_s2 && $stable(m1_s2) && $stable(m2_s2))
		else $error("final check lost while result stalled");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> angle_q == pcc_pkg::DIR_NONE && !cplx_q)
		else $error("angle state not cleared after result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s2 && done_s2))
		else $error("result without a final check");

endmodule

`default_nettype wire

/* rtl/polygon_convexity_classifier_top.sv */
// polygon_convexity_classifier_top: streams vertices, emits one class per polygon
// depends on pcc_pkg, pcc_front, pcc_queue, pcc_edge, pcc_sign
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_data (projection axis)
//   vtx     | vtx_valid / vtx_stall | pos_x, pos_y, pos_z, is_last
//   res     | res_valid / res_stall | poly_class
//
// one vertex per cycle while the queue has room and the edge sequencer is not
// closing a polygon or held by a stalled result; the last vertex of a polygon
// with three or more vertices is followed by two closing edges (SEQ_CLOSE1,
// SEQ_CLOSE2). the class is registered at the end of the two-stage cross product pipeline.
// reset clears all polygon state and sets the projection axis to x,y.
// a stalled result with the next class ready freezes the edge sequencer and the
// cross product pipeline; the queue keeps taking vertices until QUEUE_DEPTH wait.
`default_nettype none

module polygon_convexity_classifier_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_data,
	input  wire logic               vtx_valid,
	output logic                    vtx_stall,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic               is_last,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              poly_class
);

	logic          q_full, push, pop, head_valid, advance, tok_valid;
	pcc_pkg::vtx_t push_item, head;
	pcc_pkg::tok_t tok;

	pcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.is_last   (is_last),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	pcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	pcc_edge u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.advance    (advance),
		.pop        (pop),
		.tok_valid  (tok_valid),
		.tok        (tok)
	);

	pcc_sign u_sign (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (tok_valid),
		.tok        (tok),
		.advance    (advance),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.poly_class (poly_class)
	);

endmodule

`default_nettype wire
